>>> hdl/neural_activation_unit_macros.svh
// Assertion macros shared by the activation unit RTL.
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define NAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define NAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NAU_ASSERT_NOW(lbl, ante, cons, msg)
`define NAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/nau_pkg.sv
// Shared types and constants of the activation unit.
`timescale 1ns / 1ps
`default_nettype none
package nau_pkg;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 3;

  // Q32 constants of the exponential and the sigmoid
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [16:0] LN2_RECIP = 17'd94548;   // floor(2^48 / ln2_q32)
  localparam int EXP_TERMS  = 13;
  localparam int EXP_CUTOFF = 32;

  localparam int LEAKY_NUM   = 41;
  localparam int LEAKY_SHIFT = 12;
  localparam int LEAKY_HALF  = 2048;

  // sigmoid divider: 33 quotient bits, 3 per stage
  localparam int QUO_BITS   = 33;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;

  typedef enum logic [2:0] {
    FN_SIGMOID = 3'd0,
    FN_TANH    = 3'd1,
    FN_RELU    = 3'd2,
    FN_LEAKY   = 3'd3,
    FN_LINEAR  = 3'd4,
    FN_SWISH   = 3'd5
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FUNC_SEL   = 2'd0,
    REG_DERIV_MODE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] fsel;
    logic       der;
    logic       neg;
  } stage_ctl_t;
endpackage
`default_nettype wire

>>> hdl/nau_sample_if.sv
// Sample input channel.
`timescale 1ns / 1ps
`default_nettype none
interface nau_sample_if #(
  parameter int DATA_WIDTH = nau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

>>> hdl/nau_result_if.sv
// Result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface nau_result_if #(
  parameter int DATA_WIDTH = nau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_out;
  logic                         saturated;
  modport source (output valid, output result_out, output saturated, input ready);
  modport sink (input valid, input result_out, input saturated, output ready);
endinterface
`default_nettype wire

>>> hdl/nau_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface nau_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nau_pkg::CFG_INDEX_W-1:0]    index;
  logic [nau_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/neural_activation_unit.sv
// Activation unit top level: sigmoid, tanh, relu, leaky relu, linear, swish.
//
//  channel   | dir | payload                  | accepted when
//  sample_ch | in  | sample_in (Q4.12)        | valid & ready
//  result_ch | out | result_out, saturated    | valid & ready
//  cfg_ch    | in  | index, data              | valid & ready (ready always high)
//
// One sample per cycle while the output buffer is not full; the deepest parts are the Taylor series
// (3 stages per term after the first) and the 11-stage sigmoid divider.
// Reset clears valid bits, the output buffer fill count and both registers; no clearing pass.
// A two-entry output buffer takes results while result_ch stalls; the pipeline
// freezes only when both entries are full, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "neural_activation_unit_macros.svh"
module neural_activation_unit #(
  parameter int DATA_WIDTH = nau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  nau_sample_if.sink   sample_ch,
  nau_result_if.source result_ch,
  nau_cfg_if.sink      cfg_ch
);
  import nau_pkg::*;

  localparam int FXW = ((DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2) + 1;
  localparam int QW  = FXW + 32 - FRAC_BITS;
  localparam int PW  = DATA_WIDTH + 33;
  localparam logic [FXW-1:0] ONE_FX    = FXW'(1) << FRAC_BITS;
  localparam logic [FXW-1:0] LIM_FX    = FXW'(1) << (DATA_WIDTH - 1);
  localparam logic [FXW-1:0] LEAKY_DER =
    FXW'(((64'(LEAKY_NUM) << FRAC_BITS) + 64'(LEAKY_HALF)) >> LEAKY_SHIFT);
  localparam logic [QW-1:0]  RND_HALF  = QW'(1) << (31 - FRAC_BITS);

  // configuration registers
  logic [2:0] function_select;
  logic       derivative_mode;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_select <= 3'd0;
      derivative_mode <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_FUNC_SEL) begin
        function_select <= cfg_ch.data[2:0];
      end else if (cfg_ch.index == REG_DERIV_MODE) begin
        derivative_mode <= cfg_ch.data[0];
      end
    end
  end

  // output buffer occupancy gates the whole pipeline
  logic [1:0] fill, fill_next;
  logic       pipe_en;
  logic       push, pop;

  assign pipe_en         = (fill != 2'd2);
  assign sample_ch.ready = pipe_en;

  // stage 0: split sign and magnitude
  logic [DATA_WIDTH-1:0] raw;
  logic                  raw_neg;
  logic [DATA_WIDTH-1:0] raw_mag;
  logic [DATA_WIDTH-1:0] t0_mag;
  stage_ctl_t            t0_ctl;
  logic [DATA_WIDTH:0]   exp_arg;

  assign raw     = sample_ch.sample_in;
  assign raw_neg = raw[DATA_WIDTH-1];
  assign raw_mag = raw_neg ? (~raw + DATA_WIDTH'(1)) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_ctl.valid <= 1'b0;
    end else if (pipe_en) begin
      t0_ctl <= '{valid: sample_ch.valid, fsel: function_select,
                  der: derivative_mode, neg: raw_neg};
      t0_mag <= raw_mag;
    end
  end

  // tanh uses sigmoid of twice the argument
  assign exp_arg = (t0_ctl.fsel == FN_TANH) ? {t0_mag, 1'b0} : {1'b0, t0_mag};

  stage_ctl_t            ex_ctl;
  logic [DATA_WIDTH-1:0] ex_mag;
  logic [32:0]           ex_e;

  nau_exp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     (DATA_WIDTH)
  ) u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .ctl_in   (t0_ctl),
    .side_in  (t0_mag),
    .arg_in   (exp_arg),
    .ctl_out  (ex_ctl),
    .side_out (ex_mag),
    .exp_out  (ex_e)
  );

  stage_ctl_t            dv_ctl;
  logic [DATA_WIDTH-1:0] dv_mag;
  logic [32:0]           dv_p;

  nau_sigdiv #(
    .SIDE_W (DATA_WIDTH)
  ) u_sigdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .ctl_in   (ex_ctl),
    .side_in  (ex_mag),
    .exp_in   (ex_e),
    .ctl_out  (dv_ctl),
    .side_out (dv_mag),
    .sig_out  (dv_p)
  );

  // stage T1: s(1-s) and the signed-side sigmoid
  logic [32:0]           one_minus_p;
  logic [65:0]           w_prod;
  stage_ctl_t            t1_ctl;
  logic [DATA_WIDTH-1:0] t1_mag;
  logic [32:0]           t1_p;
  logic [32:0]           t1_s;
  logic [31:0]           t1_w;

  assign one_minus_p = ONE_Q32 - dv_p;
  assign w_prod      = 66'(dv_p) * 66'(one_minus_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_ctl.valid <= 1'b0;
    end else if (pipe_en) begin
      t1_ctl <= dv_ctl;
      t1_mag <= dv_mag;
      t1_p   <= dv_p;
      t1_s   <= dv_ctl.neg ? one_minus_p : dv_p;
      t1_w   <= w_prod[63:32];
    end
  end

  // stage T2: x*s and x*w for swish
  logic [PW-1:0]         xs_prod;
  logic [PW-1:0]         xw_prod;
  stage_ctl_t            t2_ctl;
  logic [DATA_WIDTH-1:0] t2_mag;
  logic [32:0]           t2_p;
  logic [32:0]           t2_s;
  logic [31:0]           t2_w;
  logic [QW-1:0]         t2_xs;
  logic [QW-1:0]         t2_xw;

  assign xs_prod = PW'(t1_mag) * PW'(t1_s);
  assign xw_prod = PW'(t1_mag) * PW'(t1_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_ctl.valid <= 1'b0;
    end else if (pipe_en) begin
      t2_ctl <= t1_ctl;
      t2_mag <= t1_mag;
      t2_p   <= t1_p;
      t2_s   <= t1_s;
      t2_w   <= t1_w;
      t2_xs  <= QW'(xs_prod >> FRAC_BITS);
      t2_xw  <= QW'(xw_prod >> FRAC_BITS);
    end
  end

  // stage T3: pick the function, Q32 for smooth ones, direct for piecewise ones
  logic [QW-1:0]             sel_q32;
  logic [FXW-1:0]            sel_fx;
  logic                      sel_smooth;
  logic                      sel_neg;
  logic                      pos_x;
  logic [DATA_WIDTH+6:0]     leaky_prod;
  stage_ctl_t                t3_ctl;
  logic [QW-1:0]             t3_q32;
  logic [FXW-1:0]            t3_fx;
  logic                      t3_smooth;
  logic                      t3_neg;

  assign pos_x      = !t2_ctl.neg && (t2_mag != '0);
  assign leaky_prod = (DATA_WIDTH+7)'(t2_mag) * (DATA_WIDTH+7)'(LEAKY_NUM)
                      + (DATA_WIDTH+7)'(LEAKY_HALF);

  always_comb begin
    sel_q32    = '0;
    sel_fx     = '0;
    sel_smooth = 1'b1;
    sel_neg    = 1'b0;
    case (t2_ctl.fsel)
      FN_SIGMOID: begin
        sel_q32 = t2_ctl.der ? QW'(t2_w) : QW'(t2_s);
      end
      FN_TANH: begin
        if (t2_ctl.der) begin
          sel_q32 = QW'(t2_w) << 2;
        end else begin
          sel_q32 = QW'({t2_p, 1'b0}) - QW'(ONE_Q32);
          sel_neg = t2_ctl.neg;
        end
      end
      FN_RELU: begin
        sel_smooth = 1'b0;
        if (pos_x) begin
          sel_fx = t2_ctl.der ? ONE_FX : FXW'(t2_mag);
        end
      end
      FN_LEAKY: begin
        sel_smooth = 1'b0;
        if (pos_x) begin
          sel_fx = t2_ctl.der ? ONE_FX : FXW'(t2_mag);
        end else if (t2_ctl.der) begin
          sel_fx = LEAKY_DER;
        end else begin
          sel_fx  = FXW'(leaky_prod >> LEAKY_SHIFT);
          sel_neg = t2_ctl.neg;
        end
      end
      FN_SWISH: begin
        if (!t2_ctl.der) begin
          sel_q32 = t2_xs;
          sel_neg = t2_ctl.neg;
        end else if (!t2_ctl.neg) begin
          sel_q32 = QW'(t2_s) + t2_xw;
        end else if (QW'(t2_s) >= t2_xw) begin
          sel_q32 = QW'(t2_s) - t2_xw;
        end else begin
          sel_q32 = t2_xw - QW'(t2_s);
          sel_neg = 1'b1;
        end
      end
      default: begin
        // linear, and the unused codes behave the same
        sel_smooth = 1'b0;
        if (t2_ctl.der) begin
          sel_fx = ONE_FX;
        end else begin
          sel_fx  = FXW'(t2_mag);
          sel_neg = t2_ctl.neg;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_ctl.valid <= 1'b0;
    end else if (pipe_en) begin
      t3_ctl    <= t2_ctl;
      t3_q32    <= sel_q32;
      t3_fx     <= sel_fx;
      t3_smooth <= sel_smooth;
      t3_neg    <= sel_neg;
    end
  end

  // round half away from zero, then clamp to the signed range
  logic [QW-1:0]         rnd_sum;
  logic [FXW-1:0]        fin_mag;
  logic                  fin_neg;
  logic [FXW-1:0]        clamp_mag;
  logic                  fin_sat;
  logic [DATA_WIDTH-1:0] fin_res;

  assign rnd_sum = t3_q32 + RND_HALF;
  assign fin_mag = t3_smooth ? FXW'(rnd_sum >> (32 - FRAC_BITS)) : t3_fx;
  assign fin_neg = t3_neg && (fin_mag != '0);

  always_comb begin
    clamp_mag = fin_mag;
    fin_sat   = 1'b0;
    if (fin_neg && (fin_mag > LIM_FX)) begin
      clamp_mag = LIM_FX;
      fin_sat   = 1'b1;
    end else if (!fin_neg && (fin_mag > LIM_FX - FXW'(1))) begin
      clamp_mag = LIM_FX - FXW'(1);
      fin_sat   = 1'b1;
    end
  end

  assign fin_res = fin_neg ? DATA_WIDTH'(~clamp_mag + FXW'(1)) : DATA_WIDTH'(clamp_mag);

  // two-entry output buffer
  logic [DATA_WIDTH-1:0] head_res, tail_res;
  logic                  head_sat, tail_sat;

  assign push = pipe_en && t3_ctl.valid;
  assign pop  = result_ch.valid && result_ch.ready;

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    case (fill)
      2'd0: begin
        if (push) begin
          head_res <= fin_res;
          head_sat <= fin_sat;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_res <= fin_res;
          head_sat <= fin_sat;
        end else if (push) begin
          tail_res <= fin_res;
          tail_sat <= fin_sat;
        end
      end
      2'd2: begin
        if (pop) begin
          head_res <= tail_res;
          head_sat <= tail_sat;
        end
      end
      default: begin
        head_res <= head_res;
      end
    endcase
  end

  assign result_ch.valid      = (fill != 2'd0);
  assign result_ch.result_out = head_res;
  assign result_ch.saturated  = head_sat;

  `NAU_ASSERT_NOW(a_fill_max, 1'b1, fill != 2'd3, "output buffer overfilled")
  `NAU_ASSERT_NEXT(a_stall_hold, !pipe_en && t3_ctl.valid, t3_ctl.valid && $stable(t3_q32), "stalled stage moved")
  `NAU_ASSERT_NOW(a_sat_limit, result_ch.valid && result_ch.saturated, (result_ch.result_out == {1'b0, {(DATA_WIDTH-1){1'b1}}}) || (result_ch.result_out == {1'b1, {(DATA_WIDTH-1){1'b0}}}), "saturated result not at a limit")
endmodule
`default_nettype wire

>>> hdl/nau_exp.sv
// Pipelined e^-a: ln2 range reduction and a 13-term Taylor series.
`timescale 1ns / 1ps
`default_nettype none
module nau_exp #(
  parameter int DATA_WIDTH = nau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nau_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  nau_pkg::stage_ctl_t ctl_in,
  input  logic [SIDE_W-1:0]   side_in,
  input  logic [DATA_WIDTH:0] arg_in,
  output nau_pkg::stage_ctl_t ctl_out,
  output logic [SIDE_W-1:0]   side_out,
  output logic [32:0]         exp_out
);
  import nau_pkg::*;

  localparam int CUT_W = (DATA_WIDTH + 1 > FRAC_BITS + 6) ? DATA_WIDTH + 1 : FRAC_BITS + 6;
  localparam logic [CUT_W-1:0] CUTOFF = CUT_W'(EXP_CUTOFF) << FRAC_BITS;
  // carried alongside the series: {r, n, cut, side}
  localparam int AW = 32 + 6 + 1 + SIDE_W;

  // stage 1: cutoff check, scale to Q32, estimate n = r / ln2
  logic [37:0] red_full;
  logic [38:0] n_prod;
  logic        x1_cut;
  logic [37:0] x1_red;
  logic [5:0]  x1_n;
  logic [SIDE_W-1:0] x1_side;
  stage_ctl_t  x1_ctl;

  assign red_full = 38'(arg_in) << (32 - FRAC_BITS);
  assign n_prod   = 39'(red_full[37:16]) * 39'(LN2_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_ctl.valid <= 1'b0;
    end else if (en) begin
      x1_ctl  <= ctl_in;
      x1_cut  <= CUT_W'(arg_in) >= CUTOFF;
      x1_red  <= red_full;
      x1_n    <= n_prod[37:32];
      x1_side <= side_in;
    end
  end

  // stage 2: n * ln2
  logic [37:0] x2_nl;
  logic        x2_cut;
  logic [37:0] x2_red;
  logic [5:0]  x2_n;
  logic [SIDE_W-1:0] x2_side;
  stage_ctl_t  x2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_ctl.valid <= 1'b0;
    end else if (en) begin
      x2_ctl  <= x1_ctl;
      x2_nl   <= 38'(x1_n) * 38'(LN2_Q32);
      x2_cut  <= x1_cut;
      x2_red  <= x1_red;
      x2_n    <= x1_n;
      x2_side <= x1_side;
    end
  end

  // stage 3: remainder, correct the estimate by one step
  logic [37:0] red_diff;
  logic [31:0] x3_r;
  logic [5:0]  x3_n;
  logic        x3_cut;
  logic [SIDE_W-1:0] x3_side;
  stage_ctl_t  x3_ctl;

  assign red_diff = x2_red - x2_nl;

  always_ff @(posedge clk) begin
    if (rst) begin
      x3_ctl.valid <= 1'b0;
    end else if (en) begin
      x3_ctl  <= x2_ctl;
      x3_cut  <= x2_cut;
      x3_side <= x2_side;
      if (red_diff >= 38'(LN2_Q32)) begin
        x3_r <= 32'(red_diff - 38'(LN2_Q32));
        x3_n <= x2_n + 6'd1;
      end else begin
        x3_r <= 32'(red_diff);
        x3_n <= x2_n;
      end
    end
  end

  // series levels: level k holds term k and the partial sum through it
  logic [31:0]        lv_term [1:EXP_TERMS];
  logic signed [34:0] lv_sum  [1:EXP_TERMS];
  logic [AW-1:0]      lv_aux  [1:EXP_TERMS];
  stage_ctl_t         lv_ctl  [1:EXP_TERMS];

  // level 1: term r, sum 1 - r
  always_ff @(posedge clk) begin
    if (rst) begin
      lv_ctl[1].valid <= 1'b0;
    end else if (en) begin
      lv_ctl[1]  <= x3_ctl;
      lv_term[1] <= x3_r;
      lv_sum[1]  <= $signed(35'(ONE_Q32)) - $signed(35'(x3_r));
      lv_aux[1]  <= {x3_r, x3_n, x3_cut, x3_side};
    end
  end

  // levels 2..13: multiply by r, divide by k, add or subtract
  for (genvar k = 2; k <= EXP_TERMS; k++) begin : g_term
    localparam logic [37:0] RK  = 38'((64'd1 << 38) / k);
    localparam bit          ODD = (k % 2) == 1;

    logic [63:0]        mul_prod;
    logic [69:0]        rcp_prod;
    logic [35:0]        chk_rem;
    logic [31:0]        quo;
    logic [31:0]        a_hi;
    logic signed [34:0] a_sum;
    logic [AW-1:0]      a_aux;
    stage_ctl_t         a_ctl;
    logic [31:0]        b_hi;
    logic [31:0]        b_q;
    logic signed [34:0] b_sum;
    logic [AW-1:0]      b_aux;
    stage_ctl_t         b_ctl;

    assign mul_prod = 64'(lv_term[k-1]) * 64'(lv_aux[k-1][AW-1 -: 32]);
    assign rcp_prod = 70'(a_hi) * 70'(RK);
    assign chk_rem  = 36'(b_hi) - 36'(b_q) * 36'(k);
    assign quo      = (chk_rem >= 36'(k)) ? b_q + 32'd1 : b_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_ctl.valid     <= 1'b0;
        b_ctl.valid     <= 1'b0;
        lv_ctl[k].valid <= 1'b0;
      end else if (en) begin
        a_ctl     <= lv_ctl[k-1];
        a_hi      <= mul_prod[63:32];
        a_sum     <= lv_sum[k-1];
        a_aux     <= lv_aux[k-1];
        b_ctl     <= a_ctl;
        b_hi      <= a_hi;
        b_q       <= rcp_prod[69:38];
        b_sum     <= a_sum;
        b_aux     <= a_aux;
        lv_ctl[k] <= b_ctl;
        lv_term[k] <= quo;
        lv_aux[k]  <= b_aux;
        if (ODD) begin
          lv_sum[k] <= b_sum - $signed(35'(quo));
        end else begin
          lv_sum[k] <= b_sum + $signed(35'(quo));
        end
      end
    end
  end

  // clamp to [0, 1], shift by n, and force zero past the cutoff
  logic [32:0] sum_clamp;
  logic [5:0]  fin_n;
  logic        fin_cut;

  assign fin_n   = lv_aux[EXP_TERMS][SIDE_W+6:SIDE_W+1];
  assign fin_cut = lv_aux[EXP_TERMS][SIDE_W];

  always_comb begin
    if (lv_sum[EXP_TERMS] < 0) begin
      sum_clamp = '0;
    end else if (lv_sum[EXP_TERMS] > $signed(35'(ONE_Q32))) begin
      sum_clamp = ONE_Q32;
    end else begin
      sum_clamp = 33'(lv_sum[EXP_TERMS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out  <= lv_ctl[EXP_TERMS];
      side_out <= lv_aux[EXP_TERMS][SIDE_W-1:0];
      exp_out  <= fin_cut ? '0 : (sum_clamp >> fin_n);
    end
  end
endmodule
`default_nettype wire

>>> hdl/nau_sigdiv.sv
// Pipelined restoring divider: sigmoid = floor(2^64 / (2^32 + e)).
`timescale 1ns / 1ps
`default_nettype none
module nau_sigdiv #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  nau_pkg::stage_ctl_t ctl_in,
  input  logic [SIDE_W-1:0]   side_in,
  input  logic [32:0]         exp_in,
  output nau_pkg::stage_ctl_t ctl_out,
  output logic [SIDE_W-1:0]   side_out,
  output logic [32:0]         sig_out
);
  import nau_pkg::*;

  logic [33:0]       dv_rem  [1:DIV_STAGES];
  logic [33:0]       dv_den  [1:DIV_STAGES];
  logic [32:0]       dv_quo  [1:DIV_STAGES];
  logic [SIDE_W-1:0] dv_side [1:DIV_STAGES];
  stage_ctl_t        dv_ctl  [1:DIV_STAGES];

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic [33:0]       src_rem;
    logic [33:0]       src_den;
    logic [32:0]       src_quo;
    logic [SIDE_W-1:0] src_side;
    stage_ctl_t        src_ctl;
    logic [33:0]       nx_rem;
    logic [32:0]       nx_quo;

    if (s == 1) begin : g_first
      // partial remainder starts at the top of the 2^64 dividend
      assign src_rem  = 34'(ONE_Q32);
      assign src_den  = 34'(ONE_Q32) + 34'(exp_in);
      assign src_quo  = '0;
      assign src_side = side_in;
      assign src_ctl  = ctl_in;
    end else begin : g_rest
      assign src_rem  = dv_rem[s-1];
      assign src_den  = dv_den[s-1];
      assign src_quo  = dv_quo[s-1];
      assign src_side = dv_side[s-1];
      assign src_ctl  = dv_ctl[s-1];
    end

    // retire three quotient bits
    always_comb begin
      nx_rem = src_rem;
      nx_quo = src_quo;
      for (int i = 0; i < DIV_STEPS; i++) begin
        if (nx_rem >= src_den) begin
          nx_rem = nx_rem - src_den;
          nx_quo = {nx_quo[31:0], 1'b1};
        end else begin
          nx_quo = {nx_quo[31:0], 1'b0};
        end
        nx_rem = nx_rem << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctl[s].valid <= 1'b0;
      end else if (en) begin
        dv_ctl[s]  <= src_ctl;
        dv_rem[s]  <= nx_rem;
        dv_den[s]  <= src_den;
        dv_quo[s]  <= nx_quo;
        dv_side[s] <= src_side;
      end
    end
  end

  assign ctl_out  = dv_ctl[DIV_STAGES];
  assign side_out = dv_side[DIV_STAGES];
  assign sig_out  = dv_quo[DIV_STAGES];
endmodule
`default_nettype wire

>>> sim/neural_activation_unit_tb.sv
// Self-checking testbench of the activation unit: directed and random samples.
`timescale 1ns / 1ps
`default_nettype none
module neural_activation_unit_tb;
  import nau_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 80;     // a little over the pipeline latency
  localparam int STALL_LIMIT  = 20000;
  localparam logic [2:0] FSEL_SPARE_LO = 3'd6;
  localparam logic [2:0] FSEL_SPARE_HI = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          sat;
  } act_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nau_sample_if #(.DATA_WIDTH(DW)) sample_ch ();
  nau_result_if #(.DATA_WIDTH(DW)) result_ch ();
  nau_cfg_if cfg_ch ();

  neural_activation_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .sample_ch(sample_ch), .result_ch(result_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  act_result_t pending_results[$];
  logic [2:0]  func_sel_shadow = FN_SIGMOID;
  logic        deriv_shadow = 1'b0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
  end

  // floor(a*b / 2^32) of two Q32 magnitudes
  function automatic bit [63:0] q32_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[95:32];
  endfunction

  // e^-(mag*mult) in Q32 by range reduction and a truncated Taylor series
  function automatic bit [63:0] exp_decay(bit [63:0] mag, bit [63:0] mult);
    bit [63:0] arg, r, n, term;
    longint    sum;
    arg = mag * mult;
    if (arg >= (64'(EXP_CUTOFF) << FB)) return 64'd0;
    r = arg << (32 - FB);
    n = r / 64'(LN2_Q32);
    r = r - n * 64'(LN2_Q32);
    sum = longint'(ONE_Q32);
    term = 64'(ONE_Q32);
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = q32_mul(term, r) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q32)) sum = longint'(ONE_Q32);
    return 64'(sum) >> n;
  endfunction

  // sigmoid of a non-negative argument: floor(2^64 / (2^32 + e))
  function automatic bit [63:0] sigmoid_pos(bit [63:0] e);
    bit [127:0] quo;
    quo = (128'd1 << 64) / ({64'd0, 64'(ONE_Q32)} + {64'd0, e});
    return quo[63:0];
  endfunction

  // expected activation or derivative of one sample under the current setup
  function automatic act_result_t activation_of(logic [DW-1:0] raw, logic [2:0] fsel,
                                                logic der);
    act_result_t res;
    bit          neg, pos, rneg, smooth;
    bit [63:0]   mag, xq, one, q32, fx, p, s, w, xw, lim;
    neg = raw[DW-1];
    mag = neg ? ((64'd1 << DW) - 64'(raw)) : 64'(raw);
    xq = mag << (32 - FB);
    one = 64'd1 << FB;
    pos = !neg && mag != 0;
    rneg = 1'b0;
    smooth = 1'b1;
    q32 = 0;
    fx = 0;
    case (fsel)
      FN_SIGMOID: begin
        p = sigmoid_pos(exp_decay(mag, 1));
        q32 = der ? q32_mul(p, 64'(ONE_Q32) - p) : (neg ? 64'(ONE_Q32) - p : p);
      end
      FN_TANH: begin
        p = sigmoid_pos(exp_decay(mag, 2));
        if (der) q32 = 4 * q32_mul(p, 64'(ONE_Q32) - p);
        else begin
          q32 = 2 * p - 64'(ONE_Q32);
          rneg = neg;
        end
      end
      FN_RELU: begin
        smooth = 1'b0;
        fx = pos ? (der ? one : mag) : 0;
      end
      FN_LEAKY: begin
        smooth = 1'b0;
        if (pos) fx = der ? one : mag;
        else if (der) fx = ((64'(LEAKY_NUM) << FB) + 64'(LEAKY_HALF)) >> LEAKY_SHIFT;
        else begin
          fx = (mag * LEAKY_NUM + 64'(LEAKY_HALF)) >> LEAKY_SHIFT;
          rneg = neg;
        end
      end
      FN_SWISH: begin
        p = sigmoid_pos(exp_decay(mag, 1));
        s = neg ? 64'(ONE_Q32) - p : p;
        if (!der) begin
          q32 = q32_mul(xq, s);
          rneg = neg;
        end else begin
          w = q32_mul(p, 64'(ONE_Q32) - p);
          xw = q32_mul(xq, w);
          if (!neg) q32 = s + xw;
          else if (s >= xw) q32 = s - xw;
          else begin
            q32 = xw - s;
            rneg = 1'b1;
          end
        end
      end
      default: begin
        // linear, and the two spare selector codes
        smooth = 1'b0;
        if (der) fx = one;
        else begin
          fx = mag;
          rneg = neg;
        end
      end
    endcase
    if (smooth) fx = (q32 + (64'd1 << (31 - FB))) >> (32 - FB);
    // clamp to the signed range
    lim = 64'd1 << (DW - 1);
    if (fx == 0) rneg = 1'b0;
    res.sat = 1'b0;
    if (rneg && fx > lim) begin
      fx = lim;
      res.sat = 1'b1;
    end else if (!rneg && fx > lim - 1) begin
      fx = lim - 1;
      res.sat = 1'b1;
    end
    res.value = rneg ? DW'(64'd0 - fx) : DW'(fx);
    return res;
  endfunction

  // random back-pressure on the result side
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    act_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h sat=%b", $time,
                 result_ch.result_out, result_ch.saturated);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.result_out !== want.value) begin
          $display("%0t: result_out expected %h actual %h", $time, want.value,
                   result_ch.result_out);
          error_count++;
        end
        if (result_ch.saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat,
                   result_ch.saturated);
          error_count++;
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // send one sample beat, idling the sender in a share of the cycles first
  task automatic send_sample(input logic [DW-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= x;
    do @(posedge clk); while (!sample_ch.ready);
    pending_results.push_back(activation_of(x, func_sel_shadow, deriv_shadow));
  endtask

  // hold off until every expected result has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write one register while the pipeline is empty
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FUNC_SEL) func_sel_shadow = val;
    else if (idx == REG_DERIV_MODE) deriv_shadow = val[0];
  endtask

  // extremes and zero for every function in both modes
  task automatic test_directed();
    logic [DW-1:0] edges[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    for (int f = 0; f < 8; f++) begin
      write_reg(REG_FUNC_SEL, 3'(f));
      for (int d = 0; d < 2; d++) begin
        write_reg(REG_DERIV_MODE, CFG_DATA_W'(d));
        for (int i = 0; i < ((f < 6) ? 3 : 1); i++) send_sample(edges[i]);
      end
    end
    // unmapped indices and high data bits must leave the setup alone
    write_reg(REG_FUNC_SEL, FN_TANH);
    write_reg(REG_DERIV_MODE, 3'd2);
    write_reg(REG_SPARE_LO, FN_RELU);
    write_reg(REG_SPARE_HI, FSEL_SPARE_HI);
    send_sample(16'h0800);
    send_sample(edges[3]);
    send_sample(edges[4]);
  endtask

  // random samples under random setups, mostly in the curved region
  task automatic test_random(input int n_items);
    int left;
    logic [DW-1:0] x;
    left = n_items;
    while (left > 0) begin
      write_reg(CFG_INDEX_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(7)));
      write_reg(REG_FUNC_SEL, $urandom_range(9) == 0 ? FSEL_SPARE_LO : 3'($urandom_range(5)));
      write_reg(REG_DERIV_MODE, CFG_DATA_W'($urandom_range(7)));
      for (int i = 0; i < 45 && left > 0; i++, left--) begin
        if ($urandom_range(2) == 0) x = DW'($urandom);
        else x = DW'($urandom_range(16384) - 8192);
        send_sample(x);
      end
    end
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(28, 88);
    test_directed();
    test_random(450);
    set_idling(88, 28);
    test_random(450);
    set_idling(0, 0);
    test_random(450);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/nau_pkg.sv
hdl/nau_sample_if.sv
hdl/nau_result_if.sv
hdl/nau_cfg_if.sv
hdl/nau_exp.sv
hdl/nau_sigdiv.sv
hdl/neural_activation_unit.sv
sim/neural_activation_unit_tb.sv
